// ===== rtl/kmt_pkg.sv =====
// Shared types and codes for the key membership table.
// Depends on nothing; imported by the top level.
package kmt_pkg;

  localparam int KEY_W  = 64;
  localparam int FILL_W = 5;

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_QUERY  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_PRESENT = 2'd3;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [FILL_W-1:0] fill_count;
  } rsp_t;

endpackage

// ===== rtl/kmt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kmt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/key_membership_table_top.sv =====
// Key membership table: unordered key set with swap-remove and fill count.
// Depends on kmt_pkg (types, codes) and kmt_ram (key storage).
//
// channel | dir | handshake            | payload
// --------+-----+----------------------+------------------------------
// req     | in  | req_valid/req_ready  | kmt_pkg::req_t {req_type, key}
// rsp     | out | rsp_valid/rsp_ready  | kmt_pkg::rsp_t {status, fill_count}
//
// Steps: add and clear need no scan; remove and query answer absent on an
//   empty table, else scan the entries from index 0 upward; a remove that
//   hits below the last entry then reads the last entry and moves it into
//   the freed slot. The single RAM read port and one shared KEY_BITS
//   comparator walk one entry per cycle.
// Reset: clears the fill count and control state only; key storage is not
//   cleared, as entries are only ever read below the count.
// Stalls: one request at a time; a finished result waits in the output
//   register, and a new request is taken while it waits.
module key_membership_table_top
  import kmt_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]          state;
  logic [CW-1:0]       count;
  logic [KEY_BITS-1:0] key_q;
  logic [1:0]          op_q;
  logic [1:0]          res_status;
  logic [AW-1:0]       rd_idx;   // read issue pointer
  logic [AW-1:0]       cmp_idx;  // entry whose data is on rdata
  logic [AW-1:0]       hit_idx;
  logic                iss_active;
  logic                cmp_valid;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [KEY_BITS-1:0] wdata;
  logic [AW-1:0]       raddr;
  logic [KEY_BITS-1:0] rdata;

  logic [CW-1:0]       cnt_m1;
  logic [AW-1:0]       last_idx;
  logic                full;
  logic                hit;
  logic [CW+FILL_W-1:0] cnt_ext;
  logic                rsp_load;

  assign cnt_m1   = count - 1'b1;
  assign last_idx = cnt_m1[AW-1:0];
  assign full     = (count >= CW'(ENTRIES));
  assign hit      = cmp_valid && (rdata == key_q);
  assign cnt_ext  = {{FILL_W{1'b0}}, count};

  assign req_ready = (state == S_IDLE);

  // output register takes a new result when empty or draining this cycle
  assign rsp_load = (state == S_RESP) && (!rsp_valid || rsp_ready);

  // Single write port: append on add, swap-in of the last entry on remove.
  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = req.key[KEY_BITS-1:0];
    if (state == S_MOVE) begin
      we    = 1'b1;
      waddr = hit_idx;
      wdata = rdata;
    end else if (state == S_IDLE && req_valid && req.req_type == REQ_ADD && !full) begin
      we = 1'b1;
    end
  end

  // Read port: scan pointer, or the last entry before a swap-remove.
  assign raddr = (state == S_LAST) ? last_idx : rd_idx;

  kmt_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rsp_valid  <= 1'b0;
      iss_active <= 1'b0;
      cmp_valid  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            key_q     <= req.key[KEY_BITS-1:0];
            op_q      <= req.req_type;
            rd_idx    <= '0;
            cmp_valid <= 1'b0;
            case (req.req_type)
              REQ_ADD: begin
                if (!full) begin
                  count      <= count + 1'b1;
                  res_status <= ST_DONE;
                end else begin
                  res_status <= ST_FULL;
                end
                state <= S_RESP;
              end
              REQ_CLEAR: begin
                count      <= '0;
                res_status <= ST_DONE;
                state      <= S_RESP;
              end
              default: begin
                // remove or query: walk the stored entries
                if (count == '0) begin
                  res_status <= ST_ABSENT;
                  state      <= S_RESP;
                end else begin
                  iss_active <= 1'b1;
                  state      <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          // issue one read per cycle, compare the previous read's data
          if (hit) begin
            iss_active <= 1'b0;
            cmp_valid  <= 1'b0;
            if (op_q == REQ_QUERY) begin
              res_status <= ST_PRESENT;
              state      <= S_RESP;
            end else if (cmp_idx == last_idx) begin
              // last entry goes: nothing to move
              count      <= cnt_m1;
              res_status <= ST_DONE;
              state      <= S_RESP;
            end else begin
              hit_idx <= cmp_idx;
              state   <= S_LAST;
            end
          end else if (cmp_valid && cmp_idx == last_idx) begin
            iss_active <= 1'b0;
            cmp_valid  <= 1'b0;
            res_status <= ST_ABSENT;
            state      <= S_RESP;
          end else begin
            if (iss_active) begin
              if (rd_idx == last_idx) begin
                iss_active <= 1'b0;
              end else begin
                rd_idx <= rd_idx + 1'b1;
              end
            end
            cmp_valid <= iss_active;
            cmp_idx   <= rd_idx;
          end
        end
        S_LAST: begin
          state <= S_MOVE;
        end
        S_MOVE: begin
          count      <= cnt_m1;
          res_status <= ST_DONE;
          state      <= S_RESP;
        end
        S_RESP: begin
          if (rsp_load) begin
            rsp.status     <= res_status;
            rsp.fill_count <= cnt_ext[FILL_W-1:0];
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES))
    else $error("fill count above table size");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (count != '0))
    else $error("scan running on an empty table");

  a_write_when: assert property (@(posedge clk) disable iff (rst)
    we |-> ((state == S_IDLE && !full) || state == S_MOVE))
    else $error("store written outside add or swap");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && rsp_valid && !rsp_ready) |=> (state == S_RESP))
    else $error("result dropped while output stalled");

  a_move_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) |=> (count == $past(count) - 1'b1))
    else $error("swap-remove did not decrement count");
`endif

endmodule
